FILE: rtl/core/lesc_pkg.sv
// Shared types and constants for the expert slot cache.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package lesc_pkg;

  localparam int ID_BITS   = 8;
  localparam int TICK_BITS = 48;
  localparam int CNT_BITS  = 32;
  localparam int CAP_BITS  = 5;
  localparam int SLOT_BITS = 4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_HIT        = 2'd0,
    ST_MISS_EMPTY = 2'd1,
    ST_EVICT      = 2'd2,
    ST_REPEAT     = 2'd3
  } status_e;

  // One tag store entry: owner id and last-use tick
  typedef struct packed {
    logic [ID_BITS-1:0]   owner;
    logic [TICK_BITS-1:0] tick;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // latch request, restart scan
    logic issue;   // read the next slot entry
    logic commit;  // apply the decision and load the result
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_issue;  // the slot being read is the last active one
    logic out_free;    // result register can take a beat
  } dp_stat_t;

endpackage

FILE: rtl/core/lesc_ctrl.sv
// Controller state machine for the expert slot cache.
// Depends on lesc_pkg for the command and status structs.
`timescale 1ns / 1ps

module lesc_ctrl
  import lesc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FLUSH  = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0] state_q, state_d;

  // Take a request only between scans
  assign in_stall_o = (state_q != S_IDLE);

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd_o.start  = 1'b0;
    cmd_o.issue  = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.last_issue) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/lesc_dp.sv
// Datapath for the expert slot cache: tag/tick memory, slot scan, decision,
// counters, capacity register and result register. Depends on lesc_pkg.
`timescale 1ns / 1ps

module lesc_dp
  import lesc_pkg::*;
#(
  parameter int MAX_SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_cmd_t             cmd_i,
  output dp_stat_t             stat_o,
  input  logic [ID_BITS-1:0]   expert_id_i,
  input  logic                 batch_start_i,
  input  logic                 cfg_valid_i,
  input  logic [CAP_BITS-1:0]  cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SLOT_BITS-1:0] slot_o,
  output logic [1:0]           status_o,
  output logic [ID_BITS-1:0]   evicted_id_o,
  output logic [CNT_BITS-1:0]  hit_count_o,
  output logic [CNT_BITS-1:0]  miss_count_o
);

  localparam int IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CntW = $clog2(MAX_SLOTS + 1);

  // Active slot count, clamped at write time
  logic [CntW-1:0] n_q, n_wr;

  always_comb begin
    if (cfg_data_i == '0) begin
      n_wr = CntW'(1);
    end else if (32'(cfg_data_i) > MAX_SLOTS) begin
      n_wr = CntW'(MAX_SLOTS);
    end else begin
      n_wr = CntW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= CntW'(MAX_SLOTS);
    end else if (cfg_valid_i) begin
      n_q <= n_wr;
    end
  end

  // Request latch
  logic [ID_BITS-1:0] id_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      id_q <= expert_id_i;
    end
  end

  // Scan address and read pipeline
  logic [IdxW-1:0] rd_idx_q, eval_idx_q;
  logic            eval_vld_q;
  entry_t          rd_q;
  entry_t          mem_q [MAX_SLOTS];

  assign stat_o.last_issue = ((CntW'(rd_idx_q) + CntW'(1)) == n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      eval_vld_q <= 1'b0;
    end else begin
      eval_vld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.issue) begin
        rd_idx_q <= IdxW'(rd_idx_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      eval_idx_q <= rd_idx_q;
    end
  end

  // Per-slot valid and batch-seen marks
  logic [MAX_SLOTS-1:0] valid_q, seen_q;

  // Scan accumulators
  logic                 found_q, empty_q;
  logic [IdxW-1:0]      match_idx_q, empty_idx_q, min_idx_q;
  logic [TICK_BITS-1:0] min_tick_q;
  logic [ID_BITS-1:0]   min_owner_q;
  logic                 ev_valid, ev_match, ev_min;

  assign ev_valid = valid_q[eval_idx_q];
  assign ev_match = ev_valid && (rd_q.owner == id_q);
  assign ev_min   = (eval_idx_q == '0) || (rd_q.tick < min_tick_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      empty_q <= 1'b0;
    end else if (cmd_i.start) begin
      found_q <= 1'b0;
      empty_q <= 1'b0;
    end else if (eval_vld_q) begin
      if (ev_match) begin
        found_q <= 1'b1;
      end
      if (!ev_valid) begin
        empty_q <= 1'b1;
      end
    end
  end

  // Keep first match, first empty and oldest tick
  always_ff @(posedge clk_i) begin
    if (eval_vld_q) begin
      if (ev_match && !found_q) begin
        match_idx_q <= eval_idx_q;
      end
      if (!ev_valid && !empty_q) begin
        empty_idx_q <= eval_idx_q;
      end
      if (ev_min) begin
        min_idx_q   <= eval_idx_q;
        min_tick_q  <= rd_q.tick;
        min_owner_q <= rd_q.owner;
      end
    end
  end

  // Decide hit, miss, eviction or repeat
  logic [IdxW-1:0]      pick;
  status_e              status;
  logic [ID_BITS-1:0]   evicted;
  logic                 upd, miss;
  logic [TICK_BITS-1:0] tick_q, tick_new;

  assign tick_new = tick_q + 1'b1;

  always_comb begin
    pick    = min_idx_q;
    status  = ST_EVICT;
    evicted = min_owner_q;
    upd     = 1'b1;
    miss    = 1'b1;
    if (found_q) begin
      pick    = match_idx_q;
      evicted = '0;
      miss    = 1'b0;
      if (seen_q[match_idx_q]) begin
        status = ST_REPEAT;
        upd    = 1'b0;
      end else begin
        status = ST_HIT;
      end
    end else if (empty_q) begin
      pick    = empty_idx_q;
      status  = ST_MISS_EMPTY;
      evicted = '0;
    end
  end

  // Tag memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && upd) begin
      mem_q[pick] <= '{owner: id_q, tick: tick_new};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_q <= mem_q[rd_idx_q];
    end
  end

  // Marks, tick and counters
  logic [CNT_BITS-1:0] hits_q, misses_q, hits_d, misses_d;

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    if (upd && !miss && (hits_q != '1)) begin
      hits_d = hits_q + 1'b1;
    end
    if (upd && miss && (misses_q != '1)) begin
      misses_d = misses_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      seen_q   <= '0;
      tick_q   <= '0;
      hits_q   <= '0;
      misses_q <= '0;
    end else if (cmd_i.start) begin
      if (batch_start_i) begin
        seen_q <= '0;
      end
    end else if (cmd_i.commit) begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      if (upd) begin
        valid_q[pick] <= 1'b1;
        seen_q[pick]  <= 1'b1;
        tick_q        <= tick_new;
      end
    end
  end

  // Result register
  logic out_valid_q;

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.commit || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      slot_o       <= SLOT_BITS'(pick);
      status_o     <= status;
      evicted_id_o <= evicted;
      hit_count_o  <= hits_d;
      miss_count_o <= misses_d;
    end
  end

endmodule

FILE: rtl/core/lru_expert_slot_cache.sv
// Expert slot cache top level: least recently used slot map for expert ids.
// Steps: accept, scan of the n active slots (capacity), flush, decide, result
// load; requests stall until then. The scan reads one tag/tick entry
// per cycle through the single read port of the tag memory.
// Reset: all slots empty, batch marks clear, tick and counters zero, capacity
// at MAX_SLOTS; no clearing pass, requests are taken right after reset.
`timescale 1ns / 1ps

module lru_expert_slot_cache
  import lesc_pkg::*;
#(
  parameter int MAX_SLOTS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CAP_BITS-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ID_BITS-1:0]   expert_id_i,
  input  logic                 batch_start_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SLOT_BITS-1:0] slot_o,
  output logic [1:0]           status_o,
  output logic [ID_BITS-1:0]   evicted_id_o,
  output logic [CNT_BITS-1:0]  hit_count_o,
  output logic [CNT_BITS-1:0]  miss_count_o
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Capacity writes land at once
  assign cfg_ready_o = 1'b1;

  lesc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lesc_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .expert_id_i   (expert_id_i),
    .batch_start_i (batch_start_i),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .slot_o        (slot_o),
    .status_o      (status_o),
    .evicted_id_o  (evicted_id_o),
    .hit_count_o   (hit_count_o),
    .miss_count_o  (miss_count_o)
  );

endmodule
